@@ rtl/pgpdf_pkg.sv @@
package pgpdf_pkg;

	typedef enum logic [1:0] {
		PH_TAG   = 2'd0,
		PH_LEN   = 2'd1,
		PH_BODY  = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		K_HEADER  = 2'd0,
		K_BODY    = 2'd1,
		K_INVALID = 2'd2,
		K_TRUNC   = 2'd3
	} kind_t;

	localparam int unsigned TAG_VALID_BIT = 7;
	localparam int unsigned TAG_NEW_BIT   = 6;
	localparam logic [1:0]  LEN_CODE_OPEN = 2'd3;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [5:0]  packet_type;
		logic [31:0] body_length;
		logic        length_unknown;
		logic [7:0]  body_data;
		logic        last;
	} result_t;

endpackage

@@ rtl/pgpdf_parse.sv @@
module pgpdf_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         data_byte,
	input  logic               stream_end,
	output pgpdf_pkg::result_t res
);

	pgpdf_pkg::phase_t phase_q, phase_d;
	logic [2:0]  len_left_q, len_left_d;
	logic [31:0] len_accum_q, len_accum_d;
	logic [31:0] body_left_q, body_left_d;
	logic        open_q, open_d;
	logic [5:0]  type_q, type_d;
	logic [31:0] decl_q, decl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pgpdf_pkg::PH_TAG;
			len_left_q  <= 3'd0;
			len_accum_q <= 32'd0;
			body_left_q <= 32'd0;
			open_q      <= 1'b0;
			type_q      <= 6'd0;
			decl_q      <= 32'd0;
		end else if (fire) begin
			phase_q     <= phase_d;
			len_left_q  <= len_left_d;
			len_accum_q <= len_accum_d;
			body_left_q <= body_left_d;
			open_q      <= open_d;
			type_q      <= type_d;
			decl_q      <= decl_d;
		end
	end

	always_comb begin
		logic [31:0] acc;
		logic [2:0]  left;
		logic [31:0] bl;
		logic        go_idle;
		acc         = {len_accum_q[23:0], data_byte};
		left        = len_left_q - 3'd1;
		bl          = body_left_q - 32'd1;
		go_idle     = 1'b0;
		phase_d     = phase_q;
		len_left_d  = len_left_q;
		len_accum_d = len_accum_q;
		body_left_d = body_left_q;
		open_d      = open_q;
		type_d      = type_q;
		decl_d      = decl_q;
		res         = '0;
		unique case (phase_q)
			pgpdf_pkg::PH_LEN: begin
				len_accum_d = acc;
				len_left_d  = left;
				if (left != 3'd0) begin
					if (stream_end) begin
						res.valid = 1'b1;
						res.kind  = pgpdf_pkg::K_TRUNC;
						res.last  = 1'b1;
						go_idle   = 1'b1;
					end
				end else begin
					decl_d            = acc;
					res.valid         = 1'b1;
					res.body_length   = acc;
					if (acc == 32'd0) begin
						res.kind = pgpdf_pkg::K_HEADER;
						res.last = 1'b1;
						go_idle  = 1'b1;
					end else if (stream_end) begin
						res.kind = pgpdf_pkg::K_TRUNC;
						res.last = 1'b1;
						go_idle  = 1'b1;
					end else begin
						res.kind    = pgpdf_pkg::K_HEADER;
						phase_d     = pgpdf_pkg::PH_BODY;
						body_left_d = acc;
					end
				end
				res.packet_type = type_q;
			end
			pgpdf_pkg::PH_BODY: begin
				res.valid       = 1'b1;
				res.packet_type = type_q;
				res.body_data   = data_byte;
				if (open_q) begin
					res.kind           = pgpdf_pkg::K_BODY;
					res.length_unknown = 1'b1;
					res.last           = stream_end;
					go_idle            = stream_end;
				end else begin
					body_left_d     = bl;
					res.body_length = decl_q;
					if (bl == 32'd0) begin
						res.kind = pgpdf_pkg::K_BODY;
						res.last = 1'b1;
						go_idle  = 1'b1;
					end else if (stream_end) begin
						res.kind = pgpdf_pkg::K_TRUNC;
						res.last = 1'b1;
						go_idle  = 1'b1;
					end else begin
						res.kind = pgpdf_pkg::K_BODY;
					end
				end
			end
			default: begin
				go_idle = 1'b1;
				res.valid = 1'b1;
				if (!data_byte[pgpdf_pkg::TAG_VALID_BIT]) begin
					res.kind = pgpdf_pkg::K_INVALID;
					res.last = 1'b1;
				end else if (data_byte[pgpdf_pkg::TAG_NEW_BIT] ||
						data_byte[1:0] == pgpdf_pkg::LEN_CODE_OPEN) begin
					type_d = data_byte[pgpdf_pkg::TAG_NEW_BIT] ? data_byte[5:0]
						: {2'b00, data_byte[5:2]};
					decl_d             = 32'd0;
					res.kind           = pgpdf_pkg::K_HEADER;
					res.packet_type    = type_d;
					res.length_unknown = 1'b1;
					res.last           = stream_end;
				end else begin
					type_d          = {2'b00, data_byte[5:2]};
					decl_d          = 32'd0;
					res.packet_type = type_d;
					if (stream_end) begin
						res.kind = pgpdf_pkg::K_TRUNC;
						res.last = 1'b1;
					end else begin
						res.valid = 1'b0;
					end
				end
			end
		endcase
		if (go_idle) begin
			phase_d     = pgpdf_pkg::PH_TAG;
			len_left_d  = 3'd0;
			len_accum_d = 32'd0;
			body_left_d = 32'd0;
			open_d      = 1'b0;
		end
		if ((phase_q == pgpdf_pkg::PH_TAG || phase_q == pgpdf_pkg::PH_SPARE) &&
				data_byte[pgpdf_pkg::TAG_VALID_BIT] && !stream_end) begin
			if (data_byte[pgpdf_pkg::TAG_NEW_BIT] ||
					data_byte[1:0] == pgpdf_pkg::LEN_CODE_OPEN) begin
				phase_d = pgpdf_pkg::PH_BODY;
				open_d  = 1'b1;
			end else begin
				phase_d    = pgpdf_pkg::PH_LEN;
				len_left_d = 3'd1 << data_byte[1:0];
			end
		end
	end

endmodule

@@ rtl/pgp_packet_deframer_core.sv @@
// Packet deframer: splits a byte stream of PGP packets into headers and bodies.
// Input channel (data_valid/data_stall) carries one stream byte per beat with
// stream_end marking the final byte of the whole stream.
// Output channel (result_valid/result_stall) carries at most one result per
// input beat: a header (type, length, unknown-length flag), a body byte, an
// invalid tag byte, or a truncated-packet mark; last closes each packet.
// Length bytes other than the final one produce no result unless stream_end marks them.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// single parse stage between the input register and the result register.
// An accepted beat is parsed from the input register and its result is loaded
// into the result register, which drives result_valid.
// Reset clears the parse state to await a tag byte and empties both registers.
// When the receiver stalls, the result register holds; the input register
// keeps one more beat, then data_stall rises until the result is taken.
module pgp_packet_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [5:0]  packet_type,
	output logic [31:0] body_length,
	output logic        length_unknown,
	output logic [7:0]  body_data,
	output logic        last
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       out_free;
	logic       fire;
	pgpdf_pkg::result_t res;

	assign out_free   = !result_valid || !result_stall;
	assign fire       = valid_s1 && out_free;
	assign data_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	pgpdf_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (byte_s1),
		.stream_end (end_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= fire && res.valid;
		end
	end

	// advance the result register only on a fresh result
	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			kind           <= res.kind;
			packet_type    <= res.packet_type;
			body_length    <= res.body_length;
			length_unknown <= res.length_unknown;
			body_data      <= res.body_data;
			last           <= res.last;
		end
	end

`ifndef SYNTHESIS
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> (result_valid && result_stall))
		else $error("input stalled while result register free");

	a_invalid_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == pgpdf_pkg::K_INVALID) |-> (last && packet_type == 6'd0))
		else $error("invalid tag result malformed");

	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == pgpdf_pkg::K_TRUNC) |-> (last && !length_unknown))
		else $error("truncated result malformed");

	a_open_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && length_unknown) |-> (body_length == 32'd0))
		else $error("unknown-length packet carries a length");
`endif

endmodule

@@ test/tb_pgp_packet_deframer_core.sv @@
module tb_pgp_packet_deframer_core;

	localparam int QUIET_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        data_valid = 1'b0;
	logic        data_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        stream_end = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  kind;
	logic [5:0]  packet_type;
	logic [31:0] body_length;
	logic        length_unknown;
	logic [7:0]  body_data;
	logic        last;

	pgp_packet_deframer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.stream_end(stream_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.packet_type(packet_type),
		.body_length(body_length),
		.length_unknown(length_unknown),
		.body_data(body_data),
		.last(last)
	);

	always #10 clk = ~clk;

	pgpdf_pkg::result_t expected_results[$];
	int          err_count = 0;
	int          beats_sent = 0;
	int          kind_seen[4] = '{0, 0, 0, 0};
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_request = 0;
	int          hold_left = 0;
	int          quiet_cycles = 0;

	pgpdf_pkg::phase_t prs_phase = pgpdf_pkg::PH_TAG;
	logic [2:0]  len_left = 3'd0;
	logic [31:0] len_acc = 32'd0;
	logic [31:0] body_left = 32'd0;
	logic        open_len = 1'b0;
	logic [5:0]  cur_type = 6'd0;
	logic [31:0] decl_len = 32'd0;

	task automatic parser_idle();
		prs_phase = pgpdf_pkg::PH_TAG;
		len_left = 3'd0;
		len_acc = 32'd0;
		body_left = 32'd0;
		open_len = 1'b0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic e);
		pgpdf_pkg::result_t r;
		bit      emits;
		r = '0;
		r.valid = 1'b1;
		emits = 1'b1;
		case (prs_phase)
			pgpdf_pkg::PH_LEN: begin
				len_acc = {len_acc[23:0], b};
				len_left = len_left - 3'd1;
				r.packet_type = cur_type;
				if (len_left != 3'd0) begin
					if (e) begin
						r.kind = pgpdf_pkg::K_TRUNC;
						r.last = 1'b1;
						parser_idle();
					end else begin
						emits = 1'b0;
					end
				end else begin
					decl_len = len_acc;
					r.body_length = decl_len;
					if (decl_len == 32'd0) begin
						r.kind = pgpdf_pkg::K_HEADER;
						r.last = 1'b1;
						parser_idle();
					end else if (e) begin
						r.kind = pgpdf_pkg::K_TRUNC;
						r.last = 1'b1;
						parser_idle();
					end else begin
						r.kind = pgpdf_pkg::K_HEADER;
						prs_phase = pgpdf_pkg::PH_BODY;
						body_left = decl_len;
					end
				end
			end
			pgpdf_pkg::PH_BODY: begin
				r.packet_type = cur_type;
				r.body_data = b;
				if (open_len) begin
					r.kind = pgpdf_pkg::K_BODY;
					r.length_unknown = 1'b1;
					r.last = e;
					if (e)
						parser_idle();
				end else begin
					body_left = body_left - 32'd1;
					r.body_length = decl_len;
					if (body_left == 32'd0) begin
						r.kind = pgpdf_pkg::K_BODY;
						r.last = 1'b1;
						parser_idle();
					end else if (e) begin
						r.kind = pgpdf_pkg::K_TRUNC;
						r.last = 1'b1;
						parser_idle();
					end else begin
						r.kind = pgpdf_pkg::K_BODY;
					end
				end
			end
			default: begin
				parser_idle();
				if (!b[pgpdf_pkg::TAG_VALID_BIT]) begin
					r.kind = pgpdf_pkg::K_INVALID;
					r.last = 1'b1;
				end else if (b[pgpdf_pkg::TAG_NEW_BIT] ||
						b[1:0] == pgpdf_pkg::LEN_CODE_OPEN) begin
					cur_type = b[pgpdf_pkg::TAG_NEW_BIT] ? b[5:0] : {2'b00, b[5:2]};
					decl_len = 32'd0;
					r.kind = pgpdf_pkg::K_HEADER;
					r.packet_type = cur_type;
					r.length_unknown = 1'b1;
					r.last = e;
					if (!e) begin
						prs_phase = pgpdf_pkg::PH_BODY;
						open_len = 1'b1;
					end
				end else begin
					cur_type = {2'b00, b[5:2]};
					decl_len = 32'd0;
					if (e) begin
						r.kind = pgpdf_pkg::K_TRUNC;
						r.packet_type = cur_type;
						r.last = 1'b1;
					end else begin
						emits = 1'b0;
						prs_phase = pgpdf_pkg::PH_LEN;
						len_left = 3'd1 << b[1:0];
					end
				end
			end
		endcase
		if (emits)
			expected_results.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			data_valid <= 1'b0;
			@(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		stream_end <= e;
		@(posedge clk);
		while (data_stall)
			@(posedge clk);
		beats_sent++;
		parse_byte(b, e);
	endtask

	task automatic wait_drained();
		data_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string fname, input logic [31:0] expv,
			input logic [31:0] actv);
		if (expv !== actv) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, expv, actv);
		end
	endtask

	always @(posedge clk) begin
		pgpdf_pkg::result_t exp_r;
		if (result_valid === 1'b1 && !result_stall) begin
			if (expected_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual kind %0d", $time, kind);
			end else begin
				exp_r = expected_results.pop_front();
				kind_seen[kind]++;
				check_field("kind", 32'(exp_r.kind), 32'(kind));
				check_field("packet_type", 32'(exp_r.packet_type), 32'(packet_type));
				check_field("body_length", exp_r.body_length, body_length);
				check_field("length_unknown", 32'(exp_r.length_unknown),
					32'(length_unknown));
				check_field("body_data", 32'(exp_r.body_data), 32'(body_data));
				check_field("last", 32'(exp_r.last), 32'(last));
			end
		end
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((data_valid && !data_stall) || (result_valid === 1'b1 && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_byte(8'h00, 1'b0);
		send_byte(8'h7f, 1'b1);
		send_byte(8'h84, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hbd, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'h86, 1'b0);
		repeat (4) send_byte(8'hff, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
		send_byte(8'ha5, 1'b1);
		send_byte(8'h83, 1'b1);
		send_byte(8'h80, 1'b1);
		send_byte(8'h86, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h88, 1'b0);
		send_byte(8'h05, 1'b1);
		send_byte(8'hc0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5a, 1'b1);
		wait_drained();
	endtask

	task automatic send_random_packet(input bit final_pkt);
		logic [7:0]  pkt[$];
		logic [1:0]  code;
		logic [31:0] plen;
		int          sel;
		int          nbody;
		int          cut;
		bit          open;
		bit          huge;
		bit          ends;
		sel = $urandom_range(0, 99);
		open = 1'b0;
		huge = 1'b0;
		nbody = 0;
		ends = 1'b0;
		if (sel < 3) begin
			pkt.push_back(8'($urandom_range(0, 255)));
			ends = $urandom_range(0, 1);
		end else if (sel < 10) begin
			pkt.push_back(8'($urandom_range(0, 127)));
		end else if (sel < 40) begin
			pkt.push_back({2'b11, 6'($urandom_range(0, 63))});
			open = 1'b1;
			nbody = $urandom_range(0, 8);
		end else if (sel < 50) begin
			pkt.push_back({2'b10, 4'($urandom_range(0, 15)), pgpdf_pkg::LEN_CODE_OPEN});
			open = 1'b1;
			nbody = $urandom_range(0, 8);
		end else begin
			code = 2'($urandom_range(0, 2));
			plen = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 6);
			if (code == 2'd0)
				plen[31:8] = '0;
			else if (code == 2'd1)
				plen[31:16] = '0;
			pkt.push_back({2'b10, 4'($urandom_range(0, 15)), code});
			for (int i = (1 << code) - 1; i >= 0; i--)
				pkt.push_back(plen[8*i +: 8]);
			huge = (plen > 32'd12);
			nbody = huge ? $urandom_range(0, 3) : int'(plen);
		end
		repeat (nbody) pkt.push_back(8'($urandom_range(0, 255)));
		if (huge || (pkt.size() > 1 && $urandom_range(0, 9) == 0)) begin
			cut = huge ? $urandom_range(0, pkt.size() - 1) : $urandom_range(0, pkt.size() - 2);
			ends = 1'b1;
		end else begin
			cut = pkt.size() - 1;
			ends = ends || open || final_pkt;
		end
		for (int i = 0; i <= cut; i++)
			send_byte(pkt[i], (i == cut) && ends);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int n);
		int target;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = beats_sent + n;
		while (beats_sent < target)
			send_random_packet($urandom_range(0, 3) == 0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 80;
		send_byte(8'hc5, 1'b0);
		repeat (28) send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'h3c, 1'b1);
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(11, 54, 650);
		test_backpressure();
		test_random(54, 11, 650);
		test_random(0, 0, 650);
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Run: %0d beats in, %0d headers, %0d body beats, %0d bad tags, %0d truncations",
			beats_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("Covered both idle mixes, no-idle streaming and a long output hold-off");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ pgp_packet_deframer_core.f @@
rtl/pgpdf_pkg.sv
rtl/pgpdf_parse.sv
rtl/pgp_packet_deframer_core.sv
test/tb_pgp_packet_deframer_core.sv
